[sv/cabb_pkg.sv]
// Shared types, register codes, opcodes and defaults for the clipped alpha blend blitter.
// Used by every module of the block and by the channel interfaces.
package cabb_pkg;

    // Frame store geometry
    localparam int STORE_AW    = 16;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int PIX_W       = 24;
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;

    // Defaults for the top-level parameters
    localparam int FRAME_WIDTH_DEF   = 256;
    localparam int FRAME_HEIGHT_DEF  = 256;
    localparam int MAX_BLIT_SIZE_DEF = 1024;

    // Signed width of a frame position: 11-bit offset plus an 11-bit column at most
    localparam int POS_W = 14;

    // Field widths
    localparam int OP_W    = 2;
    localparam int SRC_W   = 32;
    localparam int OFF_W   = 11;
    localparam int SIZE_W  = 11;
    localparam int SHIFT_W = 5;
    localparam int REG_IDX_W = 3;

    // Opcodes
    localparam logic [OP_W-1:0] OP_BLIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_DEST_X      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEST_Y      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BLIT_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BLIT_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RED_MASK    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GREEN_MASK  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BLUE_MASK   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_MASK  = 3'd7;

    // Channel slots in the mask and shift arrays
    localparam int CH_B = 0;
    localparam int CH_G = 1;
    localparam int CH_R = 2;
    localparam int CH_A = 3;

    // Register reset values
    localparam logic [SRC_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [SRC_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [SRC_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;
    localparam logic [SRC_W-1:0] ALPHA_MASK_RST = 32'hFF00_0000;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic signed [OFF_W-1:0]     dest_x;
        logic signed [OFF_W-1:0]     dest_y;
        logic [SIZE_W-1:0]           blit_width;
        logic [SIZE_W-1:0]           blit_height;
        logic [3:0][SRC_W-1:0]       mask;
        logic [3:0][SHIFT_W-1:0]     shift;
    } cfg_t;

    // One item after the front stage
    typedef struct packed {
        logic                        valid;
        logic [OP_W-1:0]             opcode;
        logic [STORE_AW-1:0]         frame_index;
        logic [PIX_W-1:0]            write_data;
        logic signed [POS_W-1:0]     px;
        logic signed [POS_W-1:0]     py;
        logic [3:0][CHAN_W-1:0]      chan;
        logic                        done;
    } front_t;

endpackage

[sv/cabb_if.sv]
// Stream channel interfaces for the blitter: command items in, result items out.
// Depends on cabb_pkg for field widths.
interface cabb_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [cabb_pkg::OP_W-1:0]      opcode;
    logic [cabb_pkg::SRC_W-1:0]     source_pixel;
    logic [cabb_pkg::STORE_AW-1:0]  frame_index;

    modport source (output valid, output opcode, output source_pixel, output frame_index,
                    input ready);
    modport sink   (input valid, input opcode, input source_pixel, input frame_index,
                    output ready);
endinterface

interface cabb_res_if;
    logic                           valid;
    logic                           ready;
    logic [cabb_pkg::PIX_W-1:0]     read_pixel;
    logic                           pixel_drawn;
    logic                           blit_done;

    modport source (output valid, output read_pixel, output pixel_drawn, output blit_done,
                    input ready);
    modport sink   (input valid, input read_pixel, input pixel_drawn, input blit_done,
                    output ready);
endinterface

[sv/clipped_alpha_blend_blit.sv]
// Top level of the clipped alpha blend blitter: config bank, front stage, frame pipeline.
// Depends on cabb_pkg, cabb_if, cabb_cfg, cabb_front and cabb_frame.
//
//   channel   dir  handshake      payload
//   cmd       in   valid/ready    opcode, source_pixel, frame_index
//   result    out  valid/ready    read_pixel, pixel_drawn, blit_done
//   cfg       in   cfg_we         cfg_index, cfg_data
//
// One item per cycle unless a result stalls; items pass the front, B, C and output
// registers. The frame store has one read and one write port; an entry is read as its
// item enters stage B and written back as it leaves C; forwarding covers the two writes
// that can overlap a read. A stalled result freezes the whole pipeline; reset clears
// valid bits and counters, frame store contents stay undefined until written.
module clipped_alpha_blend_blit #(
    parameter int FRAME_WIDTH   = cabb_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT  = cabb_pkg::FRAME_HEIGHT_DEF,
    parameter int MAX_BLIT_SIZE = cabb_pkg::MAX_BLIT_SIZE_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cabb_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [cabb_pkg::SRC_W-1:0]        cfg_data,
    cabb_cmd_if.sink                          cmd,
    cabb_res_if.source                        result
);

    cabb_pkg::cfg_t     cfg;
    cabb_pkg::front_t   front;
    logic               advance;

    // Register bank
    cabb_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Position counters and channel extraction
    cabb_front #(
        .MAX_BLIT_SIZE (MAX_BLIT_SIZE)
    ) u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .cmd     (cmd),
        .front   (front)
    );

    // Frame store read-modify-write and result register
    cabb_frame #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_frame
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .front   (front),
        .advance (advance),
        .result  (result)
    );

endmodule

[sv/cabb_cfg.sv]
// Configuration register bank with per-mask shift found at write time.
// Depends on cabb_pkg.
module cabb_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cabb_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [cabb_pkg::SRC_W-1:0]        cfg_data,
    output cabb_pkg::cfg_t                    cfg
);

    logic signed [cabb_pkg::OFF_W-1:0]   dest_x_reg;
    logic signed [cabb_pkg::OFF_W-1:0]   dest_y_reg;
    logic [cabb_pkg::SIZE_W-1:0]         width_reg;
    logic [cabb_pkg::SIZE_W-1:0]         height_reg;
    logic [3:0][cabb_pkg::SRC_W-1:0]     mask_reg;
    logic [3:0][cabb_pkg::SHIFT_W-1:0]   shift_reg;
    logic [cabb_pkg::SHIFT_W-1:0]        shift_next;

    // Lowest set bit of a mask, zero for an empty mask
    function automatic logic [cabb_pkg::SHIFT_W-1:0] low_bit(input logic [cabb_pkg::SRC_W-1:0] m);
        logic [cabb_pkg::SHIFT_W-1:0] s;
        s = '0;
        for (int i = cabb_pkg::SRC_W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                s = cabb_pkg::SHIFT_W'(i);
            end
        end
        return s;
    endfunction

    assign shift_next = low_bit(cfg_data);

    // Decode the register index and hold the written value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_x_reg   <= '0;
            dest_y_reg   <= '0;
            width_reg    <= cabb_pkg::SIZE_W'(1);
            height_reg   <= cabb_pkg::SIZE_W'(1);
            mask_reg[cabb_pkg::CH_R]  <= cabb_pkg::RED_MASK_RST;
            mask_reg[cabb_pkg::CH_G]  <= cabb_pkg::GREEN_MASK_RST;
            mask_reg[cabb_pkg::CH_B]  <= cabb_pkg::BLUE_MASK_RST;
            mask_reg[cabb_pkg::CH_A]  <= cabb_pkg::ALPHA_MASK_RST;
            shift_reg[cabb_pkg::CH_R] <= cabb_pkg::SHIFT_W'(16);
            shift_reg[cabb_pkg::CH_G] <= cabb_pkg::SHIFT_W'(8);
            shift_reg[cabb_pkg::CH_B] <= '0;
            shift_reg[cabb_pkg::CH_A] <= cabb_pkg::SHIFT_W'(24);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cabb_pkg::REG_DEST_X:      dest_x_reg <= cfg_data[cabb_pkg::OFF_W-1:0];
                cabb_pkg::REG_DEST_Y:      dest_y_reg <= cfg_data[cabb_pkg::OFF_W-1:0];
                cabb_pkg::REG_BLIT_WIDTH:  width_reg  <= cfg_data[cabb_pkg::SIZE_W-1:0];
                cabb_pkg::REG_BLIT_HEIGHT: height_reg <= cfg_data[cabb_pkg::SIZE_W-1:0];
                cabb_pkg::REG_RED_MASK:
                begin
                    mask_reg[cabb_pkg::CH_R]  <= cfg_data;
                    shift_reg[cabb_pkg::CH_R] <= shift_next;
                end
                cabb_pkg::REG_GREEN_MASK:
                begin
                    mask_reg[cabb_pkg::CH_G]  <= cfg_data;
                    shift_reg[cabb_pkg::CH_G] <= shift_next;
                end
                cabb_pkg::REG_BLUE_MASK:
                begin
                    mask_reg[cabb_pkg::CH_B]  <= cfg_data;
                    shift_reg[cabb_pkg::CH_B] <= shift_next;
                end
                cabb_pkg::REG_ALPHA_MASK:
                begin
                    mask_reg[cabb_pkg::CH_A]  <= cfg_data;
                    shift_reg[cabb_pkg::CH_A] <= shift_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.dest_x      = dest_x_reg;
    assign cfg.dest_y      = dest_y_reg;
    assign cfg.blit_width  = width_reg;
    assign cfg.blit_height = height_reg;
    assign cfg.mask        = mask_reg;
    assign cfg.shift       = shift_reg;

endmodule

[sv/cabb_front.sv]
// Front stage: source position counters, channel extraction and frame position.
// Depends on cabb_pkg and the command channel interface.
module cabb_front #(
    parameter int MAX_BLIT_SIZE = cabb_pkg::MAX_BLIT_SIZE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cabb_pkg::cfg_t        cfg,
    input  logic                  advance,
    cabb_cmd_if.sink              cmd,
    output cabb_pkg::front_t      front
);

    localparam int CNT_W = (MAX_BLIT_SIZE > 1) ? $clog2(MAX_BLIT_SIZE) : 1;

    logic [CNT_W-1:0]             col_reg, col_next;
    logic [CNT_W-1:0]             row_reg, row_next;
    logic [CNT_W:0]               col_inc, row_inc;
    logic [cabb_pkg::SIZE_W-1:0]  eff_w, eff_h;
    logic                         col_wrap, row_wrap;
    logic                         accept, blit;
    logic                         valid_reg;
    cabb_pkg::front_t             front_reg, front_next;

    // Clamp a size register to 1..MAX_BLIT_SIZE
    function automatic logic [cabb_pkg::SIZE_W-1:0] eff_size(input logic [cabb_pkg::SIZE_W-1:0] v);
        logic [cabb_pkg::SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = cabb_pkg::SIZE_W'(1);
        end
        else if (32'(v) > 32'(MAX_BLIT_SIZE))
        begin
            r = cabb_pkg::SIZE_W'(MAX_BLIT_SIZE);
        end
        return r;
    endfunction

    assign cmd.ready = advance;
    assign accept    = cmd.valid && advance;
    assign blit      = (cmd.opcode == cabb_pkg::OP_BLIT);

    // Step column and row on a blit; a counter wraps as it would reach its size
    always_comb
    begin
        eff_w    = eff_size(cfg.blit_width);
        eff_h    = eff_size(cfg.blit_height);
        col_inc  = {1'b0, col_reg} + 1'b1;
        row_inc  = {1'b0, row_reg} + 1'b1;
        col_wrap = 32'(col_inc) >= 32'(eff_w);
        row_wrap = 32'(row_inc) >= 32'(eff_h);
        col_next = col_reg;
        row_next = row_reg;
        if (blit)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_inc[CNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
            end
        end
    end

    // Build the staged item: frame position and the four extracted channels
    always_comb
    begin
        front_next             = front_reg;
        front_next.valid       = 1'b0;
        front_next.opcode      = cmd.opcode;
        front_next.frame_index = cmd.frame_index;
        front_next.write_data  = cmd.source_pixel[cabb_pkg::PIX_W-1:0];
        front_next.px          = cabb_pkg::POS_W'(cfg.dest_x) + cabb_pkg::POS_W'(col_reg);
        front_next.py          = cabb_pkg::POS_W'(cfg.dest_y) + cabb_pkg::POS_W'(row_reg);
        front_next.done        = blit && col_wrap && row_wrap;
        for (int i = 0; i < 4; i++)
        begin
            front_next.chan[i] = cabb_pkg::CHAN_W'((cmd.source_pixel & cfg.mask[i])
                                                   >> cfg.shift[i]);
        end
    end

    // Counters advance on every blit transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= cmd.valid;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Payload holds while the pipeline is stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            front_reg <= front_next;
        end
    end

    always_comb
    begin
        front       = front_reg;
        front.valid = valid_reg;
    end

endmodule

[sv/cabb_frame.sv]
// Frame store with read-modify-write blend pipeline, forwarding and the result register.
// Depends on cabb_pkg and the result channel interface.
module cabb_frame #(
    parameter int FRAME_WIDTH  = cabb_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = cabb_pkg::FRAME_HEIGHT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cabb_pkg::front_t      front,
    output logic                  advance,
    cabb_res_if.source            result
);

    localparam int AW = cabb_pkg::STORE_AW;
    localparam int PW = cabb_pkg::PIX_W;
    localparam int CW = cabb_pkg::CHAN_W;
    localparam int NC = cabb_pkg::NUM_CHAN;
    localparam int MW = 2 * CW;

    localparam logic [AW-1:0] FW_L  = AW'(FRAME_WIDTH);
    localparam logic [AW-1:0] FH1_L = AW'(FRAME_HEIGHT - 1);
    localparam logic signed [cabb_pkg::POS_W-1:0] FW_POS = cabb_pkg::POS_W'(FRAME_WIDTH);
    localparam logic signed [cabb_pkg::POS_W-1:0] FH_POS = cabb_pkg::POS_W'(FRAME_HEIGHT);

    logic [PW-1:0]            mem [cabb_pkg::STORE_DEPTH];
    logic [PW-1:0]            q_reg;

    // Address stage signals
    logic                     in_frame;
    logic [AW-1:0]            row_addr, pix_addr, a_addr;
    logic                     a_we, a_blit;

    // Stage B: read data returns
    logic                     b_valid_reg;
    logic [cabb_pkg::OP_W-1:0] b_op_reg;
    logic                     b_we_reg, b_drawn_reg, b_done_reg;
    logic [AW-1:0]            b_addr_reg;
    logic [PW-1:0]            b_wd_reg;
    logic [3:0][CW-1:0]       b_chan_reg;
    logic [PW-1:0]            old_pix;

    // Last write, for the read that shared its edge
    logic                     lw_valid_reg;
    logic [AW-1:0]            lw_addr_reg;
    logic [PW-1:0]            lw_data_reg;

    // Stage C: products registered, blend and write-back
    logic                     c_valid_reg;
    logic [cabb_pkg::OP_W-1:0] c_op_reg;
    logic                     c_we_reg, c_drawn_reg, c_done_reg;
    logic [AW-1:0]            c_addr_reg;
    logic [PW-1:0]            c_wd_reg, c_rd_reg;
    logic [NC-1:0][MW-1:0]    c_po_reg, c_ps_reg;
    logic [NC-1:0][MW-1:0]    po_next, ps_next;
    logic [PW-1:0]            c_wdata;
    logic                     c_write;

    // Output register
    logic                     o_valid_reg;
    logic [PW-1:0]            o_rd_reg;
    logic                     o_drawn_reg, o_done_reg;

    assign advance = !o_valid_reg || result.ready;

    // Clip against the frame and form the store address
    always_comb
    begin
        a_blit   = (front.opcode == cabb_pkg::OP_BLIT);
        in_frame = (front.px >= 0) && (front.px < FW_POS)
                && (front.py >= 0) && (front.py < FH_POS);
        row_addr = FH1_L - AW'(front.py);
        pix_addr = row_addr * FW_L + AW'(front.px);
        a_addr   = a_blit ? pix_addr : front.frame_index;
        a_we     = (a_blit && in_frame) || (front.opcode == cabb_pkg::OP_WRITE);
    end

    // Memory port: write-back from stage C, read for the incoming item (old data on a clash)
    assign c_write = c_valid_reg && c_we_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (c_write)
            begin
                mem[c_addr_reg] <= c_wdata;
            end
            q_reg <= mem[a_addr];
        end
    end

    // Forward the write in flight, then the write that shared the read edge
    always_comb
    begin
        if (c_write && (c_addr_reg == b_addr_reg))
        begin
            old_pix = c_wdata;
        end
        else if (lw_valid_reg && (lw_addr_reg == b_addr_reg))
        begin
            old_pix = lw_data_reg;
        end
        else
        begin
            old_pix = q_reg;
        end
    end

    // Blend products per channel
    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            po_next[i] = MW'(old_pix[i*CW +: CW]) * MW'(cabb_pkg::CHAN_MAX - b_chan_reg[cabb_pkg::CH_A]);
            ps_next[i] = MW'(b_chan_reg[i]) * MW'(b_chan_reg[cabb_pkg::CH_A]);
        end
    end

    // Sum and exact divide by 255: (s + 1 + (s >> 8)) >> 8 holds for s up to 255*255
    always_comb
    begin
        logic [MW:0] s;
        logic [MW:0] t;
        s = '0;
        t = '0;
        c_wdata = c_wd_reg;
        if (c_op_reg == cabb_pkg::OP_BLIT)
        begin
            for (int i = 0; i < NC; i++)
            begin
                s = (MW+1)'(c_po_reg[i]) + (MW+1)'(c_ps_reg[i]);
                t = s + (MW+1)'(1) + (s >> CW);
                c_wdata[i*CW +: CW] = t[MW-1:CW];
            end
        end
    end

    // Valid bits for each stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg  <= front.valid;
            c_valid_reg  <= b_valid_reg;
            o_valid_reg  <= c_valid_reg;
            lw_valid_reg <= c_write;
        end
    end

    // Advance the payload of every stage together
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_op_reg    <= front.opcode;
            b_we_reg    <= a_we;
            b_drawn_reg <= a_blit && in_frame;
            b_done_reg  <= front.done;
            b_addr_reg  <= a_addr;
            b_wd_reg    <= front.write_data;
            b_chan_reg  <= front.chan;

            lw_addr_reg <= c_addr_reg;
            lw_data_reg <= c_wdata;

            c_op_reg    <= b_op_reg;
            c_we_reg    <= b_we_reg;
            c_drawn_reg <= b_drawn_reg;
            c_done_reg  <= b_done_reg;
            c_addr_reg  <= b_addr_reg;
            c_wd_reg    <= b_wd_reg;
            c_rd_reg    <= (b_op_reg == cabb_pkg::OP_READ) ? old_pix : '0;
            c_po_reg    <= po_next;
            c_ps_reg    <= ps_next;

            o_rd_reg    <= c_rd_reg;
            o_drawn_reg <= c_drawn_reg;
            o_done_reg  <= c_done_reg;
        end
    end

    assign result.valid       = o_valid_reg;
    assign result.read_pixel  = o_rd_reg;
    assign result.pixel_drawn = o_drawn_reg;
    assign result.blit_done   = o_done_reg;

endmodule
